@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while rs is high.
`define ASSERT_IMPLY(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while rs is high.
`define ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/acso_pkg.sv @@
package acso_pkg;

  localparam int CHANNELS_DEF     = 8;
  localparam int SAMPLE_SHIFT_DEF = 3;
  localparam int MUX_BITS_DEF     = 5;

  localparam int SAMPLE_W   = 10;
  localparam int SLOT_W     = 3;
  localparam int CODE_W     = 5;
  localparam int COUNT_W    = 4;
  localparam int LIST_W     = 40;
  localparam int MAX_SLOTS  = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // output tdata layout
  localparam int OUT_MUX_LSB    = 0;
  localparam int OUT_READ_LSB   = OUT_MUX_LSB + CODE_W;
  localparam int OUT_SSLOT_LSB  = OUT_READ_LSB + SAMPLE_W;
  localparam int OUT_SVAL_LSB   = OUT_SSLOT_LSB + SLOT_W;
  localparam int OUT_USED_W     = OUT_SVAL_LSB + SAMPLE_W;

  typedef enum logic [0:0] {
    OP_CONVERT = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_CHANNEL_LIST  = 1'b1
  } reg_index_t;

endpackage

@@ hdl/adc_scan_oversample_averager_core.sv @@
// Round-robin ADC scan with oversampling average. Each beat on the slave side
// is either a conversion result (tuser = 0) or a read of a slot's stored average
// (tuser = 1), and produces exactly one beat on the master side in the next cycle.
// The first 2**SAMPLE_SHIFT conversions of a slot are summed, the next one is
// dropped, the scaled-down sum is stored as that slot's average and the scan
// advances to the next slot's mux code. Throughput is one item per clock: the
// whole update is a single add and compare ahead of one result register, and
// the slave side stays ready while that register is empty or being drained.
// Configuration writes (index 0: channel count, index 1: packed mux codes) are
// accepted whenever the block is out of reset and belong only in idle periods.
module adc_scan_oversample_averager_core #(
  parameter int CHANNELS     = acso_pkg::CHANNELS_DEF,
  parameter int SAMPLE_SHIFT = acso_pkg::SAMPLE_SHIFT_DEF,
  parameter int MUX_BITS     = acso_pkg::MUX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [acso_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // sample, read_slot, zero pad
  input  logic [0:0]                         s_axis_tuser,  // operation
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [acso_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // mux_select, read_value,
                                                            // stored_slot, stored_value, pad
  output logic [0:0]                         m_axis_tuser,  // stored
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [acso_pkg::LIST_W-1:0]        cfg_data
);
  import acso_pkg::*;

  localparam int SUM_W = SAMPLE_W + SAMPLE_SHIFT;
  localparam int CNT_W = SAMPLE_SHIFT + 1;
  localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(2 ** SAMPLE_SHIFT);
  localparam logic [CODE_W-1:0] CODE_KEEP  = CODE_W'((2 ** MUX_BITS) - 1);
  localparam logic [COUNT_W-1:0] CHAN_MAX  = COUNT_W'(CHANNELS);

  logic [SUM_W-1:0]    sample_sum, sample_sum_next;
  logic [CNT_W-1:0]    sample_count, sample_count_next;
  logic [SLOT_W-1:0]   current_slot, current_slot_next;
  logic [SAMPLE_W-1:0] slot_average [CHANNELS];
  logic [COUNT_W-1:0]  channel_count;
  logic [LIST_W-1:0]   channel_list;

  logic                in_beat;
  op_t                 op;
  logic [SAMPLE_W-1:0] sample;
  logic [SLOT_W-1:0]   read_slot;

  logic [COUNT_W-1:0]  eff_count;
  logic [COUNT_W-1:0]  slot_inc;
  logic [SAMPLE_W-1:0] avg;
  logic                store;
  logic [SAMPLE_W-1:0] read_value;
  logic [CODE_W-1:0]   mux_select;

  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready     = !rst;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign op        = op_t'(s_axis_tuser[0]);
  assign sample    = s_axis_tdata[SAMPLE_W-1:0];
  assign read_slot = s_axis_tdata[SAMPLE_W +: SLOT_W];

  always_comb begin
    eff_count = channel_count;
    if (eff_count == '0) eff_count = COUNT_W'(1);
    if (eff_count > CHAN_MAX) eff_count = CHAN_MAX;
  end

  assign slot_inc = COUNT_W'(current_slot) + COUNT_W'(1);
  assign avg      = SAMPLE_W'(sample_sum >> SAMPLE_SHIFT);

  always_comb begin
    sample_sum_next   = sample_sum;
    sample_count_next = sample_count;
    current_slot_next = current_slot;
    store             = 1'b0;
    read_value        = '0;
    unique case (op)
      OP_READ: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (read_slot == SLOT_W'(i)) read_value = slot_average[i];
        end
      end
      OP_CONVERT: begin
        if (sample_count < COUNT_FULL) begin
          sample_count_next = sample_count + CNT_W'(1);
          sample_sum_next   = sample_sum + SUM_W'(sample);
        end else begin
          store             = 1'b1;
          sample_sum_next   = '0;
          sample_count_next = '0;
          current_slot_next = (slot_inc < eff_count) ? SLOT_W'(slot_inc) : '0;
        end
      end
      default: ;
    endcase
  end

  assign mux_select = CODE_W'(channel_list >> (CODE_W * current_slot_next)) & CODE_KEEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      current_slot  <= '0;
      channel_count <= COUNT_W'(1);
      channel_list  <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) slot_average[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_index_t'(cfg_index))
          REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
          REG_CHANNEL_LIST:  channel_list  <= cfg_data;
          default: ;
        endcase
      end
      if (in_beat) begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count_next;
        current_slot <= current_slot_next;
        for (int i = 0; i < CHANNELS; i++) begin
          if (store && current_slot == SLOT_W'(i)) slot_average[i] <= avg;
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= {
        (OUT_DATA_W - OUT_USED_W)'(0),
        store ? avg : SAMPLE_W'(0),
        store ? current_slot : SLOT_W'(0),
        read_value,
        mux_select
      };
      m_axis_tuser[0] <= store;
    end
  end

endmodule

@@ hdl/acso_checker.sv @@
`include "assert_macros.svh"

module acso_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [acso_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser
);
  import acso_pkg::*;

  logic in_beat;
  logic stall;
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign stall   = m_axis_tvalid && !m_axis_tready;

  // every accepted beat shows up as a result next cycle
  `ASSERT_NEXT(a_beat_to_result, clk, rst, in_beat, m_axis_tvalid)
  // a stalled result is held
  `ASSERT_NEXT(a_hold_stall, clk, rst, stall, m_axis_tvalid)
  // nothing pending after reset
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)
  // no store: stored slot and value are zero
  `ASSERT_IMPLY(a_no_store_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata[OUT_USED_W-1:OUT_SSLOT_LSB] == '0)
  // a store never carries read data
  `ASSERT_IMPLY(a_store_no_read, clk, rst, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[OUT_SSLOT_LSB-1:OUT_READ_LSB] == '0)

endmodule

bind adc_scan_oversample_averager_core acso_checker u_acso_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/adc_scan_oversample_averager_core_tb.sv @@
module adc_scan_oversample_averager_core_tb;
  import acso_pkg::*;

  localparam int SHIFT       = SAMPLE_SHIFT_DEF;
  localparam int SLOTS       = CHANNELS_DEF;
  localparam int CODE_KEEP   = (1 << MUX_BITS_DEF) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 155;

  typedef struct packed {
    logic [CODE_W-1:0]   mux;
    logic [SAMPLE_W-1:0] read_val;
    logic                stored;
    logic [SLOT_W-1:0]   st_slot;
    logic [SAMPLE_W-1:0] st_val;
  } scan_result_t;

  class scan_average_tracker;
    logic [12:0]         acc_sum;
    int                  acc_count;
    logic [SLOT_W-1:0]   scan_slot;
    logic [SAMPLE_W-1:0] averages [SLOTS];
    logic [COUNT_W-1:0]  slot_total;
    logic [LIST_W-1:0]   mux_table;
    scan_result_t        results_due [$];
    int                  errors;

    function new();
      acc_sum    = '0;
      acc_count  = 0;
      scan_slot  = '0;
      slot_total = 4'd1;
      mux_table  = '0;
      errors     = 0;
      foreach (averages[i]) averages[i] = '0;
    endfunction

    function void note_config(reg_index_t idx, logic [LIST_W-1:0] v);
      case (idx)
        REG_CHANNEL_COUNT: slot_total = v[COUNT_W-1:0];
        REG_CHANNEL_LIST:  mux_table = v;
      endcase
    endfunction

    function void apply_item(op_t op, logic [SAMPLE_W-1:0] smp, logic [SLOT_W-1:0] rs);
      scan_result_t        r;
      int                  lanes;
      logic [SAMPLE_W-1:0] avg;
      r = '0;
      lanes = (slot_total == 0) ? 1 : (slot_total > SLOTS) ? SLOTS : int'(slot_total);
      if (op == OP_READ) begin
        if (rs < SLOTS) r.read_val = averages[rs];
      end else if (acc_count < (1 << SHIFT)) begin
        acc_count++;
        acc_sum += 13'(smp);
      end else begin
        // conversion after a full set is dropped; the set closes here
        avg = SAMPLE_W'(acc_sum >> SHIFT);
        averages[scan_slot] = avg;
        r.stored  = 1'b1;
        r.st_slot = scan_slot;
        r.st_val  = avg;
        acc_sum   = '0;
        acc_count = 0;
        if (scan_slot + 1 < lanes) scan_slot = scan_slot + 1'b1;
        else scan_slot = '0;
      end
      r.mux = CODE_W'((mux_table >> (CODE_W * scan_slot)) & CODE_KEEP);
      results_due.push_back(r);
    endfunction

    function int field_diff(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] d, logic [0:0] u);
      scan_result_t want;
      int           bad;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat expected none actual tdata=%h tuser=%0d",
                 $time, d, u);
        errors++;
        return;
      end
      want = results_due.pop_front();
      bad = 0;
      bad += field_diff("mux_select", int'(want.mux), int'(d[OUT_MUX_LSB +: CODE_W]));
      bad += field_diff("read_value", int'(want.read_val),
                        int'(d[OUT_READ_LSB +: SAMPLE_W]));
      bad += field_diff("stored", int'(want.stored), int'(u[0]));
      bad += field_diff("stored_slot", int'(want.st_slot),
                        int'(d[OUT_SSLOT_LSB +: SLOT_W]));
      bad += field_diff("stored_value", int'(want.st_val),
                        int'(d[OUT_SVAL_LSB +: SAMPLE_W]));
      if (bad != 0) errors++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [LIST_W-1:0]     cfg_data = '0;

  scan_average_tracker tracker = new();
  bit no_idle = 1'b0;
  int stall_left = 0;
  int dead_cycles = 0;

  adc_scan_oversample_averager_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
    end
    if (dead_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called and returns at a falling edge; tvalid stays high for a back-to-back beat
  task automatic issue(op_t op, logic [SAMPLE_W-1:0] smp, logic [SLOT_W-1:0] rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_DATA_W'({rs, smp});
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    tracker.apply_item(op, smp, rs);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [LIST_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (tracker.results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [COUNT_W-1:0] counts [PHASES];
    logic [LIST_W-1:0]  count_word;
    logic [LIST_W-1:0]  list_word;
    counts = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd5, 4'd9, 4'd0};
    counts[PHASES-1] = COUNT_W'($urandom_range(0, 15));

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset defaults: one slot, all mux codes zero
    issue(OP_READ, '0, 3'd0);
    issue(OP_READ, '0, 3'd7);
    repeat (8) issue(OP_CONVERT, 10'h3FF, 3'd0);
    issue(OP_CONVERT, 10'h000, 3'd0);
    issue(OP_READ, 10'h3FF, 3'd0);
    repeat (8) issue(OP_CONVERT, 10'h000, 3'd7);
    issue(OP_CONVERT, 10'h3FF, 3'd0);
    issue(OP_READ, '0, 3'd0);
    issue(OP_READ, 10'h155, 3'd5);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      no_idle = (ph % 3 == 2);
      count_word = LIST_W'({$urandom, $urandom});
      count_word[COUNT_W-1:0] = counts[ph];
      if (ph == 1) list_word = '1;
      else if (ph == 2) list_word = '0;
      else list_word = LIST_W'({$urandom, $urandom});
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_CHANNEL_COUNT, count_word);
        write_reg(REG_CHANNEL_LIST, list_word);
      end else begin
        write_reg(REG_CHANNEL_LIST, list_word);
        write_reg(REG_CHANNEL_COUNT, count_word);
      end
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 20)
          issue(OP_READ, SAMPLE_W'($urandom), SLOT_W'($urandom_range(0, 7)));
        else
          issue(OP_CONVERT, SAMPLE_W'($urandom_range(0, 1023)), SLOT_W'($urandom));
      end
    end

    no_idle = 1'b0;
    wait_idle();
    if (tracker.errors == 0 && tracker.results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
